/* rtl/quote_change_rate_window_defines.svh */
// ----------------------------------------------------------------------------
// quote change rate window assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef QUOTE_CHANGE_RATE_WINDOW_DEFINES_SVH
`define QUOTE_CHANGE_RATE_WINDOW_DEFINES_SVH

`ifndef SYNTHESIS

`define QCRW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define QCRW_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define QCRW_ASSERT(label, clk, rst, prop, msg)

`define QCRW_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

/* rtl/qcrw_pkg.sv */
// ----------------------------------------------------------------------------
// quote change rate window package
// widths, depths and controller to datapath types
// ----------------------------------------------------------------------------
package qcrw_pkg;

   localparam int HIST_DEPTH  = 2048;
   localparam int HIST_ADDR_W = $clog2(HIST_DEPTH);
   localparam int CNT_W       = HIST_ADDR_W + 1;
   localparam int PRICE_W     = 32;
   localparam int SUM_W       = PRICE_W + 1;
   localparam int WINDOW_W    = 12;
   localparam int RATE_W      = 17;
   localparam int DIV_STEPS   = RATE_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(50);

   typedef struct packed {
      logic take;
      logic read;
      logic commit;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

/* rtl/qcrw_req_if.sv */
// ----------------------------------------------------------------------------
// quote change rate window request channel
// valid/ready channel carrying one book update per beat
// ----------------------------------------------------------------------------
interface qcrw_req_if;

   logic                            valid;
   logic                            ready;
   logic [qcrw_pkg::PRICE_W-1:0]    bid_price_ticks;
   logic [qcrw_pkg::PRICE_W-1:0]    ask_price_ticks;
   logic                            book_present;

   modport source (
      output valid,
      output bid_price_ticks,
      output ask_price_ticks,
      output book_present,
      input  ready
   );

   modport sink (
      input  valid,
      input  bid_price_ticks,
      input  ask_price_ticks,
      input  book_present,
      output ready
   );

endinterface

/* rtl/qcrw_rsp_if.sv */
// ----------------------------------------------------------------------------
// quote change rate window response channel
// valid/ready channel carrying one rate result per beat
// ----------------------------------------------------------------------------
interface qcrw_rsp_if;

   logic                            valid;
   logic                            ready;
   logic [qcrw_pkg::RATE_W-1:0]     change_rate;
   logic [qcrw_pkg::WINDOW_W-1:0]   changes_in_window;
   logic [qcrw_pkg::WINDOW_W-1:0]   window_used;

   modport source (
      output valid,
      output change_rate,
      output changes_in_window,
      output window_used,
      input  ready
   );

   modport sink (
      input  valid,
      input  change_rate,
      input  changes_in_window,
      input  window_used,
      output ready
   );

endinterface

/* rtl/qcrw_ram.sv */
// ----------------------------------------------------------------------------
// quote change rate window generic ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module qcrw_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2048
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/qcrw_ctrl.sv */
// ----------------------------------------------------------------------------
// quote change rate window controller
// sequences lookup, history write, division and result hand-off
// ----------------------------------------------------------------------------
`include "quote_change_rate_window_defines.svh"

module qcrw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_book_present,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output qcrw_pkg::cmd_type     cmd,
   input  qcrw_pkg::status_type  status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_book_present) begin
               cmd.take = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.commit = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `QCRW_ASSERT(a_take_starts_read, clock, reset, (state_ff == ST_IDLE && req_valid && req_book_present) |=> (state_ff == ST_READ), "accepted update did not start a lookup")
   `QCRW_ASSERT(a_stalled_result_held, clock, reset, (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE && rsp_valid_ff), "result overwritten while stalled")
   `QCRW_ASSERT(a_divide_runs_out, clock, reset, (state_ff == ST_DIVIDE && !status.div_last) |=> (state_ff == ST_DIVIDE), "division left early")

endmodule

/* rtl/qcrw_datapath.sv */
// ----------------------------------------------------------------------------
// quote change rate window datapath
// reference tracking, count history, window lookup and rate divider
// ----------------------------------------------------------------------------
`include "quote_change_rate_window_defines.svh"

module qcrw_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [qcrw_pkg::WINDOW_W-1:0]     csr_write_data,
   input  logic [qcrw_pkg::PRICE_W-1:0]      bid_price_ticks,
   input  logic [qcrw_pkg::PRICE_W-1:0]      ask_price_ticks,
   input  qcrw_pkg::cmd_type                 cmd,
   output qcrw_pkg::status_type              status,
   output logic [qcrw_pkg::RATE_W-1:0]       change_rate,
   output logic [qcrw_pkg::WINDOW_W-1:0]     changes_in_window,
   output logic [qcrw_pkg::WINDOW_W-1:0]     window_used
);

   // control state
   logic [qcrw_pkg::WINDOW_W-1:0]    window_ff,   window_in;
   logic                             have_ref_ff, have_ref_in;
   logic [qcrw_pkg::CNT_W-1:0]       total_ff,    total_in;
   logic [qcrw_pkg::HIST_ADDR_W-1:0] wp_ff,       wp_in;
   logic [qcrw_pkg::CNT_W-1:0]       fill_ff,     fill_in;

   // payload state
   logic [qcrw_pkg::SUM_W-1:0]       last_sum_ff, last_sum_in;
   logic [qcrw_pkg::CNT_W-1:0]       m_ff,        m_in;
   logic                             base_zero_ff, base_zero_in;
   logic [qcrw_pkg::CNT_W-1:0]       changes_ff,  changes_in;
   logic [qcrw_pkg::CNT_W:0]         rem_ff,      rem_in;
   logic [qcrw_pkg::RATE_W-1:0]      quot_ff,     quot_in;
   logic                             first_ff,    first_in;
   logic [qcrw_pkg::DIV_CNT_W-1:0]   cnt_ff,      cnt_in;
   logic [qcrw_pkg::RATE_W-1:0]      rate_ff,     rate_in;
   logic [qcrw_pkg::WINDOW_W-1:0]    chg_out_ff,  chg_out_in;
   logic [qcrw_pkg::WINDOW_W-1:0]    used_out_ff, used_out_in;

   logic [qcrw_pkg::SUM_W-1:0]       price_sum;
   logic                             fill_full;
   logic [qcrw_pkg::CNT_W-1:0]       fill_inc;
   logic [qcrw_pkg::CNT_W-1:0]       win_clamp;
   logic [qcrw_pkg::CNT_W-1:0]       m_new;
   logic [qcrw_pkg::HIST_ADDR_W-1:0] rd_addr;
   logic [qcrw_pkg::CNT_W-1:0]       rd_data;
   logic [qcrw_pkg::CNT_W-1:0]       baseline;
   logic [qcrw_pkg::CNT_W:0]         m_ext;
   logic [qcrw_pkg::CNT_W:0]         trial;
   logic [qcrw_pkg::CNT_W:0]         trial_sub;
   logic                             trial_ge;

   assign price_sum = {1'b0, bid_price_ticks} + {1'b0, ask_price_ticks};
   assign fill_full = (fill_ff == qcrw_pkg::CNT_W'(qcrw_pkg::HIST_DEPTH));
   assign fill_inc  = fill_full ? fill_ff : fill_ff + qcrw_pkg::CNT_W'(1);

   always_comb begin
      priority if (window_ff == '0) begin
         win_clamp = qcrw_pkg::CNT_W'(1);
      end else if (window_ff > qcrw_pkg::WINDOW_W'(qcrw_pkg::HIST_DEPTH)) begin
         win_clamp = qcrw_pkg::CNT_W'(qcrw_pkg::HIST_DEPTH);
      end else begin
         win_clamp = qcrw_pkg::CNT_W'(window_ff);
      end
   end

   assign m_new = (win_clamp < fill_inc) ? win_clamp : fill_inc;

   // slot holding the count from m updates before the newest one
   assign rd_addr  = wp_ff - m_ff[qcrw_pkg::HIST_ADDR_W-1:0];
   assign baseline = base_zero_ff ? '0 : rd_data;

   assign m_ext     = {1'b0, m_ff};
   assign trial     = first_ff ? rem_ff : {rem_ff[qcrw_pkg::CNT_W-1:0], 1'b0};
   assign trial_ge  = (trial >= m_ext);
   assign trial_sub = trial - m_ext;

   assign status.div_last = (cnt_ff == qcrw_pkg::DIV_CNT_W'(qcrw_pkg::DIV_STEPS - 1));

   qcrw_ram #(
      .WIDTH (qcrw_pkg::CNT_W),
      .DEPTH (qcrw_pkg::HIST_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (wp_ff),
      .wr_data (total_ff),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      window_in    = csr_write_enable ? csr_write_data : window_ff;
      have_ref_in  = have_ref_ff;
      total_in     = total_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      last_sum_in  = last_sum_ff;
      m_in         = m_ff;
      base_zero_in = base_zero_ff;
      changes_in   = changes_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      first_in     = first_ff;
      cnt_in       = cnt_ff;
      rate_in      = rate_ff;
      chg_out_in   = chg_out_ff;
      used_out_in  = used_out_ff;

      if (cmd.take) begin
         if (!have_ref_ff) begin
            have_ref_in = 1'b1;
            last_sum_in = price_sum;
         end else if (price_sum != last_sum_ff) begin
            total_in    = total_ff + qcrw_pkg::CNT_W'(1);
            last_sum_in = price_sum;
         end
         fill_in      = fill_inc;
         m_in         = m_new;
         base_zero_in = (m_new == fill_inc) && !fill_full;
      end

      if (cmd.commit) begin
         wp_in      = wp_ff + qcrw_pkg::HIST_ADDR_W'(1);
         changes_in = total_ff - baseline;
         rem_in     = {1'b0, total_ff - baseline};
         quot_in    = '0;
         first_in   = 1'b1;
         cnt_in     = '0;
      end

      if (cmd.div_step) begin
         rem_in   = trial_ge ? trial_sub : trial;
         quot_in  = {quot_ff[qcrw_pkg::RATE_W-2:0], trial_ge};
         first_in = 1'b0;
         cnt_in   = cnt_ff + qcrw_pkg::DIV_CNT_W'(1);
      end

      if (cmd.load_out) begin
         rate_in     = quot_ff;
         chg_out_in  = qcrw_pkg::WINDOW_W'(changes_ff);
         used_out_in = qcrw_pkg::WINDOW_W'(m_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= qcrw_pkg::WINDOW_RESET;
         have_ref_ff <= 1'b0;
         total_ff    <= '0;
         wp_ff       <= '0;
         fill_ff     <= '0;
      end else begin
         window_ff   <= window_in;
         have_ref_ff <= have_ref_in;
         total_ff    <= total_in;
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      last_sum_ff  <= last_sum_in;
      m_ff         <= m_in;
      base_zero_ff <= base_zero_in;
      changes_ff   <= changes_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      first_ff     <= first_in;
      cnt_ff       <= cnt_in;
      rate_ff      <= rate_in;
      chg_out_ff   <= chg_out_in;
      used_out_ff  <= used_out_in;
   end

   assign change_rate       = rate_ff;
   assign changes_in_window = chg_out_ff;
   assign window_used       = used_out_ff;

   `QCRW_ASSERT(a_window_nonzero, clock, reset, cmd.take |=> (m_ff != '0 && m_ff <= fill_ff), "covered window empty or beyond history")
   `QCRW_ASSERT(a_remainder_bound, clock, reset, cmd.div_step |=> (rem_ff < m_ext), "divider remainder not below divisor")

endmodule

/* rtl/quote_change_rate_window.sv */
// ----------------------------------------------------------------------------
// quote change rate window
// mid-quote change count and rate over a sliding window of book updates
// ----------------------------------------------------------------------------
// req_chan takes one book update per beat. An update without book_present is
// taken while idle and dropped with no response. An update with both sides
// present yields one beat on rsp_chan: the rate as unsigned 1.16 (65536 = 1.0),
// the change count and the number of updates the window covers.
// csr_write_enable / csr_write_data set the window length (reset 50). The user
// must write it only while no update is in flight; the block does not enforce it.
// An accepted update goes through history lookup, history write, a 17-step
// radix-2 divider, then the output register before its response beat.
// An update with a book is finished before the next one is accepted;
// req_chan.ready is high only while no update is in flight.
// The output register holds a result until taken, so the next update can be
// accepted while rsp_chan is stalled; a finished result then waits until the
// output register frees before being loaded.
// Reset clears the reference, counts, fill level and ring pointer; the history
// ram needs no clearing since only slots already written are looked up.
// ----------------------------------------------------------------------------
module quote_change_rate_window (
   input  logic                            clock,
   input  logic                            reset,
   qcrw_req_if.sink                        req_chan,
   qcrw_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [qcrw_pkg::WINDOW_W-1:0]   csr_write_data
);

   qcrw_pkg::cmd_type    cmd;
   qcrw_pkg::status_type status;

   qcrw_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_book_present (req_chan.book_present),
      .req_ready        (req_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .cmd              (cmd),
      .status           (status)
   );

   qcrw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .bid_price_ticks   (req_chan.bid_price_ticks),
      .ask_price_ticks   (req_chan.ask_price_ticks),
      .cmd               (cmd),
      .status            (status),
      .change_rate       (rsp_chan.change_rate),
      .changes_in_window (rsp_chan.changes_in_window),
      .window_used       (rsp_chan.window_used)
   );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// quote change rate window testbench
// drives book updates through valid/ready with random gaps on both channels,
// tracks the mid-quote reference, change count and history ring in a local
// predictor and checks each rate beat field by field, in order. a directed
// table comes first, then random phases over several window lengths, from a
// single update up to beyond the history depth.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [qcrw_pkg::RATE_W-1:0]   change_rate;
      logic [qcrw_pkg::WINDOW_W-1:0] changes_in_window;
      logic [qcrw_pkg::WINDOW_W-1:0] window_used;
   } rate_result_type;

   typedef struct packed {
      logic [qcrw_pkg::PRICE_W-1:0] bid;
      logic [qcrw_pkg::PRICE_W-1:0] ask;
      logic                         present;
      logic                         typed;
      rate_result_type              want;
   } book_row_type;

   localparam int DIRECTED_ROWS = 15;
   localparam int PHASES        = 10;
   localparam int SETTLE_CYCLES = 25;
   localparam int MAX_REPORTS   = 100;

   // window 50 from reset; typed rows are read straight off the change sequence
   localparam book_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{32'd100,       32'd102,       1'b1, 1'b1, '{17'd0,     12'd0, 12'd1}},
      '{32'd0,         32'd0,         1'b0, 1'b0, '{17'd0,     12'd0, 12'd0}},
      '{32'd100,       32'd102,       1'b1, 1'b1, '{17'd0,     12'd0, 12'd2}},
      '{32'd101,       32'd102,       1'b1, 1'b1, '{17'd21845, 12'd1, 12'd3}},
      '{32'hFFFFFFFF,  32'hFFFFFFFF,  1'b1, 1'b1, '{17'd32768, 12'd2, 12'd4}},
      '{32'hFFFFFFFF,  32'hFFFFFFFF,  1'b0, 1'b0, '{17'd0,     12'd0, 12'd0}},
      '{32'd0,         32'd0,         1'b1, 1'b1, '{17'd39321, 12'd3, 12'd5}},
      '{32'hFFFFFFFF,  32'd0,         1'b1, 1'b1, '{17'd43690, 12'd4, 12'd6}},
      '{32'd0,         32'hFFFFFFFF,  1'b1, 1'b0, '{17'd0,     12'd0, 12'd0}},
      '{32'h80000000,  32'h7FFFFFFF,  1'b1, 1'b0, '{17'd0,     12'd0, 12'd0}},
      '{32'h80000000,  32'h80000000,  1'b1, 1'b0, '{17'd0,     12'd0, 12'd0}},
      '{32'h55555555,  32'hAAAAAAAA,  1'b1, 1'b0, '{17'd0,     12'd0, 12'd0}},
      '{32'hAAAAAAAA,  32'h55555555,  1'b1, 1'b0, '{17'd0,     12'd0, 12'd0}},
      '{32'h12345678,  32'h9ABCDEF0,  1'b0, 1'b0, '{17'd0,     12'd0, 12'd0}},
      '{32'h7FFFFFFF,  32'h80000000,  1'b1, 1'b0, '{17'd0,     12'd0, 12'd0}}
   };

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_write_enable;
   logic [qcrw_pkg::WINDOW_W-1:0] csr_write_data;

   qcrw_req_if req_chan ();
   qcrw_rsp_if rsp_chan ();

   quote_change_rate_window dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [qcrw_pkg::WINDOW_W-1:0]    window_reg    = qcrw_pkg::WINDOW_RESET;
   logic [qcrw_pkg::SUM_W-1:0]       mid_sum_ref   = '0;
   bit                               mid_sum_valid = 1'b0;
   logic [31:0]                      mid_changes   = '0;
   logic [31:0]                      totals_ring [qcrw_pkg::HIST_DEPTH];
   logic [qcrw_pkg::HIST_ADDR_W-1:0] ring_slot     = '0;
   int                               ring_count    = 0;

   rate_result_type expected_rates [$];
   int              mismatch_count = 0;

   logic [qcrw_pkg::PRICE_W-1:0] last_bid = '0;
   logic [qcrw_pkg::PRICE_W-1:0] last_ask = '0;
   int                           send_calm = 0;
   int                           recv_calm = 0;

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   function automatic int draw_idle(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 99) == 0) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 60);
   endfunction

   task automatic predict_change_rate(input logic [qcrw_pkg::PRICE_W-1:0] bid,
                                      input logic [qcrw_pkg::PRICE_W-1:0] ask,
                                      input logic present,
                                      output bit produced,
                                      output rate_result_type result);
      logic [qcrw_pkg::SUM_W-1:0]       sum;
      logic [31:0]                      prior;
      logic [31:0]                      floor_count;
      logic [31:0]                      window_changes;
      logic [qcrw_pkg::HIST_ADDR_W-1:0] slot;
      logic [47:0]                      scaled;
      int                               fill_before;
      int                               span;
      int                               covered;
      produced = 1'b0;
      result   = '0;
      if (!present)
         return;
      sum = qcrw_pkg::SUM_W'(bid) + qcrw_pkg::SUM_W'(ask);
      if (!mid_sum_valid) begin
         mid_sum_ref   = sum;
         mid_sum_valid = 1'b1;
      end else if (sum != mid_sum_ref) begin
         mid_changes = mid_changes + 32'd1;
         mid_sum_ref = sum;
      end
      slot              = ring_slot;
      prior             = totals_ring[slot];
      totals_ring[slot] = mid_changes;
      ring_slot         = slot + 1'b1;
      fill_before       = ring_count;
      if (ring_count < qcrw_pkg::HIST_DEPTH)
         ring_count++;
      span = (window_reg == 0) ? 1 : int'(window_reg);
      if (span > qcrw_pkg::HIST_DEPTH)
         span = qcrw_pkg::HIST_DEPTH;
      covered = (span < ring_count) ? span : ring_count;
      if (covered < ring_count)
         floor_count = totals_ring[qcrw_pkg::HIST_ADDR_W'(int'(slot) - covered)];
      else if (fill_before >= qcrw_pkg::HIST_DEPTH)
         floor_count = prior;
      else
         floor_count = '0;
      window_changes             = mid_changes - floor_count;
      scaled                     = {window_changes, 16'h0000};
      result.change_rate         = qcrw_pkg::RATE_W'(scaled / 48'(covered));
      result.changes_in_window   = qcrw_pkg::WINDOW_W'(window_changes);
      result.window_used         = qcrw_pkg::WINDOW_W'(covered);
      produced                   = 1'b1;
   endtask

   // one update per call; returns at the edge where the beat is taken
   task automatic offer_update(input logic [qcrw_pkg::PRICE_W-1:0] bid,
                               input logic [qcrw_pkg::PRICE_W-1:0] ask,
                               input logic present,
                               input logic typed,
                               input rate_result_type want);
      int              gap;
      bit              produced;
      rate_result_type result;
      gap = draw_idle(send_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.bid_price_ticks <= bid;
      req_chan.ask_price_ticks <= ask;
      req_chan.book_present    <= present;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_change_rate(bid, ask, present, produced, result);
      if (produced)
         expected_rates.push_back(typed ? want : result);
   endtask

   task automatic make_update(output logic [qcrw_pkg::PRICE_W-1:0] bid,
                              output logic [qcrw_pkg::PRICE_W-1:0] ask,
                              output logic present);
      longint unsigned sum;
      longint unsigned lo;
      longint unsigned hi;
      int              mode;
      logic [31:0]     corners [4];
      corners = '{32'd0, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF};
      present = ($urandom_range(0, 99) < 88);
      mode    = $urandom_range(0, 9);
      if (mode <= 2) begin
         bid = last_bid;
         ask = last_ask;
      end else if (mode <= 4) begin
         // same mid, different split
         sum = longint'(last_bid) + longint'(last_ask);
         lo  = (sum > 64'hFFFFFFFF) ? sum - 64'hFFFFFFFF : 0;
         hi  = (sum < 64'hFFFFFFFF) ? sum : 64'hFFFFFFFF;
         bid = $urandom_range(32'(hi), 32'(lo));
         ask = 32'(sum - longint'(bid));
      end else if (mode <= 6) begin
         bid = last_bid + $urandom_range(0, 2);
         ask = last_ask - $urandom_range(0, 2);
      end else if (mode <= 8) begin
         bid = $urandom;
         ask = $urandom;
      end else begin
         bid = corners[$urandom_range(0, 3)];
         ask = corners[$urandom_range(0, 3)];
      end
      if (present) begin
         last_bid = bid;
         last_ask = ask;
      end
   endtask

   task automatic settle_block();
      while (expected_rates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [qcrw_pkg::WINDOW_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_reg = value;
   endtask

   // result sink: random stalls
   initial begin : rsp_stall
      int stall;
      forever begin
         stall = draw_idle(recv_calm);
         if (stall == 0) begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rate_result_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_rates.size() == 0) begin
            flag_mismatch($sformatf("beat with nothing pending: rate=%0d changes=%0d used=%0d",
                          rsp_chan.change_rate, rsp_chan.changes_in_window,
                          rsp_chan.window_used));
         end else begin
            want = expected_rates.pop_front();
            if (rsp_chan.change_rate !== want.change_rate)
               flag_mismatch($sformatf("change_rate got %0d want %0d",
                             rsp_chan.change_rate, want.change_rate));
            if (rsp_chan.changes_in_window !== want.changes_in_window)
               flag_mismatch($sformatf("changes_in_window got %0d want %0d",
                             rsp_chan.changes_in_window, want.changes_in_window));
            if (rsp_chan.window_used !== want.window_used)
               flag_mismatch($sformatf("window_used got %0d want %0d",
                             rsp_chan.window_used, want.window_used));
         end
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int                           phase_window [PHASES];
      int                           phase_items  [PHASES];
      logic [qcrw_pkg::PRICE_W-1:0] bid;
      logic [qcrw_pkg::PRICE_W-1:0] ask;
      logic                         present;
      reset                    <= 1'b1;
      csr_write_enable         <= 1'b0;
      csr_write_data           <= '0;
      req_chan.valid           <= 1'b0;
      req_chan.bid_price_ticks <= '0;
      req_chan.ask_price_ticks <= '0;
      req_chan.book_present    <= 1'b0;
      // the long windows cover the whole history seen so far
      phase_window = '{1, 0, 3, 50, 2048, 4095, 2047, 0, 0, 2048};
      phase_items  = '{60, 40, 60, 80, 400, 200, 120, 80, 100, 95};
      phase_window[7] = $urandom_range(4, 2046);
      phase_window[8] = $urandom_range(2049, 4094);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         offer_update(DIRECTED_TABLE[i].bid, DIRECTED_TABLE[i].ask,
                      DIRECTED_TABLE[i].present, DIRECTED_TABLE[i].typed,
                      DIRECTED_TABLE[i].want);
         if (DIRECTED_TABLE[i].present) begin
            last_bid = DIRECTED_TABLE[i].bid;
            last_ask = DIRECTED_TABLE[i].ask;
         end
      end
      req_chan.valid <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         settle_block();
         write_window(qcrw_pkg::WINDOW_W'(phase_window[p]));
         for (int i = 0; i < phase_items[p]; i++) begin
            make_update(bid, ask, present);
            offer_update(bid, ask, present, 1'b0, '0);
         end
         req_chan.valid <= 1'b0;
      end

      while (expected_rates.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
